// File: design/beoa_pkg.sv
// ----------------------------------------------------------------------------
// beoa_pkg
// Shared types and constants for the button / encoder offset adjuster.
// ----------------------------------------------------------------------------
package beoa_pkg;

    // field widths
    localparam int SAMPLE_W = 8;
    localparam int OFFSET_W = 32;
    localparam int EXP_W    = 5;

    // exponent limits and reset value
    localparam int          MAX_EXPONENT_DEF = 30;
    localparam logic [4:0]  RESET_EXPONENT   = 5'd16;

    // bit positions inside one gpio sample
    localparam int BIT_NORTH  = 0;
    localparam int BIT_SOUTH  = 1;
    localparam int BIT_WEST   = 2;
    localparam int BIT_EAST   = 3;
    localparam int BIT_CENTER = 4;
    localparam int BIT_PUSH   = 5;
    localparam int BIT_PHA    = 6;
    localparam int BIT_PHB    = 7;

    // events decoded from one sample
    typedef struct packed {
        logic north;
        logic south;
        logic west;
        logic east;
        logic clear;
        logic enc_inc;
        logic enc_dec;
    } beoa_events_t;

endpackage

// File: design/beoa_edge.sv
// ----------------------------------------------------------------------------
// beoa_edge
// Rising edge and quadrature step detection against the previous sample.
// ----------------------------------------------------------------------------
module beoa_edge
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic [beoa_pkg::SAMPLE_W-1:0]  sample,
    output beoa_pkg::beoa_events_t         events
);

    logic [beoa_pkg::SAMPLE_W-1:0] last_sample_reg;
    logic [beoa_pkg::SAMPLE_W-1:0] last_sample_next;
    logic [beoa_pkg::SAMPLE_W-1:0] rise;
    logic [beoa_pkg::SAMPLE_W-1:0] changed;
    logic                          phase_x;

    // previous sample, taken when the item is consumed
    assign last_sample_next = load ? sample : last_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg <= '0;
        end
        else
        begin
            last_sample_reg <= last_sample_next;
        end
    end

    // edge and change masks
    assign rise    = sample & ~last_sample_reg;
    assign changed = sample ^ last_sample_reg;
    assign phase_x = sample[beoa_pkg::BIT_PHA] ^ sample[beoa_pkg::BIT_PHB];

    // event decode, phase A rule wins when both phases moved
    always_comb
    begin
        events.north   = rise[beoa_pkg::BIT_NORTH];
        events.south   = rise[beoa_pkg::BIT_SOUTH];
        events.west    = rise[beoa_pkg::BIT_WEST];
        events.east    = rise[beoa_pkg::BIT_EAST];
        events.clear   = rise[beoa_pkg::BIT_CENTER] | rise[beoa_pkg::BIT_PUSH];
        events.enc_inc = 1'b0;
        events.enc_dec = 1'b0;
        if (changed[beoa_pkg::BIT_PHA])
        begin
            events.enc_inc = phase_x;
            events.enc_dec = ~phase_x;
        end
        else if (changed[beoa_pkg::BIT_PHB])
        begin
            events.enc_inc = ~phase_x;
            events.enc_dec = phase_x;
        end
    end

endmodule

// File: design/beoa_update.sv
// ----------------------------------------------------------------------------
// beoa_update
// Exponent and offset state, updated once per consumed sample.
// ----------------------------------------------------------------------------
module beoa_update
#(
    parameter int MAX_EXPONENT = beoa_pkg::MAX_EXPONENT_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  beoa_pkg::beoa_events_t        events,
    input  logic [beoa_pkg::EXP_W-1:0]    default_exp,
    output logic [beoa_pkg::OFFSET_W-1:0] offset,
    output logic [beoa_pkg::EXP_W-1:0]    exponent
);

    logic [beoa_pkg::OFFSET_W-1:0] offset_reg;
    logic [beoa_pkg::OFFSET_W-1:0] offset_next;
    logic [beoa_pkg::EXP_W-1:0]    exp_reg;
    logic [beoa_pkg::EXP_W-1:0]    exp_next;

    logic [beoa_pkg::EXP_W-1:0]    exp_a;
    logic [beoa_pkg::EXP_W-1:0]    exp_b;
    logic [beoa_pkg::EXP_W-1:0]    exp_c;
    logic [beoa_pkg::OFFSET_W-1:0] step_b;
    logic [beoa_pkg::OFFSET_W-1:0] step_c;
    logic [beoa_pkg::OFFSET_W-1:0] off_b;
    logic [beoa_pkg::OFFSET_W-1:0] off_c;
    logic [beoa_pkg::OFFSET_W-1:0] off_d;

    // north / south adjust the exponent
    always_comb
    begin
        exp_a = exp_reg;
        if (events.north && (exp_reg < beoa_pkg::EXP_W'(MAX_EXPONENT)))
        begin
            exp_a = exp_reg + 1'b1;
        end
        exp_b = exp_a;
        if (events.south && (exp_a != '0))
        begin
            exp_b = exp_a - 1'b1;
        end
    end

    // west / east step, then center or push clear
    always_comb
    begin
        step_b = beoa_pkg::OFFSET_W'(1) << exp_b;
        off_b  = offset_reg;
        if (events.west && !events.east)
        begin
            off_b = offset_reg + step_b;
        end
        else if (events.east && !events.west)
        begin
            off_b = offset_reg - step_b;
        end
        if (events.clear)
        begin
            off_c = '0;
            exp_c = default_exp;
        end
        else
        begin
            off_c = off_b;
            exp_c = exp_b;
        end
    end

    // encoder step with the final exponent
    always_comb
    begin
        step_c = beoa_pkg::OFFSET_W'(1) << exp_c;
        if (events.enc_inc)
        begin
            off_d = off_c + step_c;
        end
        else if (events.enc_dec)
        begin
            off_d = off_c - step_c;
        end
        else
        begin
            off_d = off_c;
        end
    end

    assign offset_next = load ? off_d : offset_reg;
    assign exp_next    = load ? exp_c : exp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            exp_reg    <= beoa_pkg::RESET_EXPONENT;
        end
        else
        begin
            offset_reg <= offset_next;
            exp_reg    <= exp_next;
        end
    end

    assign offset   = offset_reg;
    assign exponent = exp_reg;

endmodule

// File: design/button_encoder_offset_adjust.sv
// ----------------------------------------------------------------------------
// button_encoder_offset_adjust
// Push button and quadrature encoder driven offset / step exponent adjuster.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one gpio sample per transfer (buttons, push, phases A/B).
//   m_* channel: one result per sample: the offset and the step exponent
//     after that sample has been applied.
//   cfg_we / cfg_wdata: load the default exponent (restored on center or
//     encoder push); write only while the block is idle.
// Timing:
//   A sample goes into an input register, then the decode and update logic
//   loads the state registers, which drive m_tdata, and sets m_tvalid. One
//   sample per cycle is sustained while m_tready stays high; the limit is the
//   single input register feeding the state update.
// Reset:
//   Offset clears, exponent and default exponent go to 16, the previous
//   sample reads as all zeros, and both channels are empty.
// Stall:
//   While m_tready is low the result holds, the input register keeps its
//   sample, and s_tready drops once that register is full.
// ----------------------------------------------------------------------------
module button_encoder_offset_adjust
#(
    parameter int MAX_EXPONENT = beoa_pkg::MAX_EXPONENT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] gpio_sample
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] offset_out, [36:32] exponent_out, [39:37] zero
    // configuration
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [beoa_pkg::SAMPLE_W-1:0] in_sample_reg;
    logic [beoa_pkg::SAMPLE_W-1:0] in_sample_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [beoa_pkg::EXP_W-1:0]    default_exp_reg;
    logic [beoa_pkg::EXP_W-1:0]    default_exp_next;
    logic                          advance;
    logic                          s_xfer;
    beoa_pkg::beoa_events_t        events;
    logic [beoa_pkg::OFFSET_W-1:0] offset;
    logic [beoa_pkg::EXP_W-1:0]    exponent;

    // handshake: stage advances when the result slot is free or drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    assign in_valid_next    = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign in_sample_next   = s_xfer ? s_tdata : in_sample_reg;
    assign out_valid_next   = advance ? 1'b1 : ((m_tready) ? 1'b0 : out_valid_reg);
    assign default_exp_next = cfg_we ? cfg_wdata : default_exp_reg;

    // control and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            default_exp_reg <= beoa_pkg::RESET_EXPONENT;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            default_exp_reg <= default_exp_next;
        end
    end

    // input sample register
    always_ff @(posedge clk)
    begin
        in_sample_reg <= in_sample_next;
    end

    // edge detection
    beoa_edge u_edge
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .sample (in_sample_reg),
        .events (events)
    );

    // state update
    beoa_update
    #(
        .MAX_EXPONENT (MAX_EXPONENT)
    )
    u_update
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .events      (events),
        .default_exp (default_exp_reg),
        .offset      (offset),
        .exponent    (exponent)
    );

    // result output
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, exponent, offset};

    // a stalled result keeps the pending sample in the input register
    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |=> in_valid_reg)
        else $error("pending sample dropped during output stall");

    // no new sample accepted into a full stage that cannot move
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> !s_tready)
        else $error("input register overwritten while full");

    // a sample with no events leaves the offset unchanged
    a_quiet_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !events.west && !events.east && !events.clear
            && !events.enc_inc && !events.enc_dec) |=> $stable(offset))
        else $error("offset changed without an event");

    // the result only moves when a sample is consumed
    a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance) |=> ($stable(offset) && $stable(exponent)))
        else $error("result changed without a consumed sample");

endmodule

// File: tb/sv/button_encoder_offset_adjust_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_encoder_offset_adjust_tb
// Self-checking bench for the button / quadrature encoder offset adjuster.
// Gpio samples go in on the s_* stream and every result on the m_* stream is
// compared against an in-bench model of the offset and step exponent. A short
// table of hand-picked samples and default exponent loads comes first, then
// random phases of quadrature walks, noise and held samples with random gaps
// on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module button_encoder_offset_adjust_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_SAMPLES  = 110;
    localparam int DIR_ROWS       = 29;

    typedef enum logic { ROW_SAMPLE, ROW_DEFAULT } row_kind_t;

    typedef enum int { GEN_QUAD, GEN_NOISE, GEN_HOLD } sample_gen_t;

    typedef struct packed {
        logic [beoa_pkg::OFFSET_W-1:0] offset;
        logic [beoa_pkg::EXP_W-1:0]    exponent;
    } adjust_t;

    typedef struct packed {
        row_kind_t                     kind;
        logic [7:0]                    value;
        logic                          typed;
        logic [beoa_pkg::OFFSET_W-1:0] offset;
        logic [beoa_pkg::EXP_W-1:0]    exponent;
    } dir_row_t;

    // hand-picked rows; results typed in only where they are obvious
    localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        // every bit rising on the first sample after reset
        '{ROW_SAMPLE,  8'hFF, 1'b1, 32'hFFFF_0000, 5'd16},
        // both phases fall together
        '{ROW_SAMPLE,  8'h00, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h01, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h02, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h04, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h08, 1'b0, 32'h0, 5'd0},
        // phase a alone, then phase b alone, in both directions
        '{ROW_SAMPLE,  8'h40, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'hC0, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h80, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h00, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h80, 1'b0, 32'h0, 5'd0},
        // encoder push with a phase b edge, then center
        '{ROW_SAMPLE,  8'h20, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h10, 1'b0, 32'h0, 5'd0},
        // lowest default: south stuck at zero, step of one
        '{ROW_DEFAULT, 8'd0,  1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h20, 1'b1, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h02, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h04, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h08, 1'b0, 32'h0, 5'd0},
        // highest legal default: north held at the limit
        '{ROW_DEFAULT, 8'd30, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h10, 1'b1, 32'h0, 5'd30},
        '{ROW_SAMPLE,  8'h01, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h04, 1'b0, 32'h0, 5'd0},
        // default above the limit: step of 2^31, offset wraps
        '{ROW_DEFAULT, 8'd31, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h20, 1'b1, 32'h0, 5'd31},
        '{ROW_SAMPLE,  8'h01, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h04, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h00, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h04, 1'b0, 32'h0, 5'd0},
        '{ROW_SAMPLE,  8'h02, 1'b0, 32'h0, 5'd0}
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [4:0]  cfg_wdata = 5'd0;

    // model state
    logic [7:0]                    model_prev;
    logic [beoa_pkg::EXP_W-1:0]    model_exp;
    logic [beoa_pkg::OFFSET_W-1:0] model_offset;
    logic [beoa_pkg::EXP_W-1:0]    model_default;

    adjust_t     offset_exp_q[$];
    adjust_t     head_result;
    logic [1:0]  enc_pos;
    logic [7:0]  last_sent;
    bit          tx_steady;
    bit          rx_steady;
    int unsigned n_samples;
    int unsigned n_directed;
    int unsigned n_results;
    int unsigned n_defaults;
    int unsigned n_errors;
    int unsigned stall_cycles;

    button_encoder_offset_adjust uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // apply one gpio sample to the model and return offset and exponent
    function automatic adjust_t advance_offset(input logic [7:0] now);
        logic [7:0] rise;
        logic [7:0] moved;
        logic       ab_xor;
        adjust_t    res;
        rise   = now & ~model_prev;
        moved  = now ^ model_prev;
        ab_xor = now[beoa_pkg::BIT_PHA] ^ now[beoa_pkg::BIT_PHB];
        if (rise[beoa_pkg::BIT_NORTH] && model_exp < beoa_pkg::MAX_EXPONENT_DEF)
            model_exp = model_exp + 5'd1;
        if (rise[beoa_pkg::BIT_SOUTH] && model_exp != 5'd0)
            model_exp = model_exp - 5'd1;
        if (rise[beoa_pkg::BIT_WEST])
            model_offset = model_offset + (32'd1 << model_exp);
        if (rise[beoa_pkg::BIT_EAST])
            model_offset = model_offset - (32'd1 << model_exp);
        if (rise[beoa_pkg::BIT_CENTER] || rise[beoa_pkg::BIT_PUSH])
        begin
            model_offset = '0;
            model_exp    = model_default;
        end
        // phase a edge wins when both phases moved
        if (moved[beoa_pkg::BIT_PHA])
            model_offset = ab_xor ? model_offset + (32'd1 << model_exp)
                                  : model_offset - (32'd1 << model_exp);
        else if (moved[beoa_pkg::BIT_PHB])
            model_offset = ab_xor ? model_offset - (32'd1 << model_exp)
                                  : model_offset + (32'd1 << model_exp);
        model_prev   = now;
        res.offset   = model_offset;
        res.exponent = model_exp;
        return res;
    endfunction

    // mostly legal quadrature walks with sparse buttons, some noise and holds
    function automatic logic [7:0] next_gpio_sample();
        logic [7:0]  sample;
        logic [1:0]  ab;
        sample_gen_t gen;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        gen  = (pick < 65) ? GEN_QUAD : (pick < 85) ? GEN_NOISE : GEN_HOLD;
        case (gen)
            GEN_QUAD:
            begin
                enc_pos = enc_pos + ($urandom_range(0, 1) ? 2'd1 : 2'd3);
                ab      = enc_pos ^ (enc_pos >> 1);
                sample  = 8'h00;
                sample[3:0]                  = 4'($urandom & $urandom);
                sample[beoa_pkg::BIT_CENTER] = ($urandom_range(0, 11) == 0);
                sample[beoa_pkg::BIT_PUSH]   = ($urandom_range(0, 11) == 0);
                sample[beoa_pkg::BIT_PHA]    = ab[0];
                sample[beoa_pkg::BIT_PHB]    = ab[1];
            end
            GEN_NOISE:
                sample = 8'($urandom_range(0, 255));
            default:
                sample = last_sent;
        endcase
        last_sent = sample;
        return sample;
    endfunction

    // one input transfer after a random gap; the model runs at acceptance
    task automatic send_sample(input logic [7:0] sample, input logic typed,
                               input adjust_t typed_res);
        int unsigned gap;
        adjust_t     res;
        gap = tx_steady ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        do @(posedge clk); while (!s_tready);
        res = advance_offset(sample);
        offset_exp_q.push_back(typed ? typed_res : res);
        n_samples++;
        @(negedge clk);
    endtask

    // drain all results, then load the default exponent
    task automatic load_default(input logic [4:0] value);
        s_tvalid <= 1'b0;
        while (offset_exp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we        <= 1'b0;
        model_default  = value;
        n_defaults++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (offset_exp_q.size() == 0)
            begin
                $error("result transfer with nothing pending: m_tdata %h", m_tdata);
                n_errors++;
            end
            else
            begin
                head_result = offset_exp_q.pop_front();
                if (m_tdata[31:0] !== head_result.offset)
                begin
                    $error("offset_out: expected %h, got %h", head_result.offset,
                           m_tdata[31:0]);
                    n_errors++;
                end
                if (m_tdata[36:32] !== head_result.exponent)
                begin
                    $error("exponent_out: expected %0d, got %0d", head_result.exponent,
                           m_tdata[36:32]);
                    n_errors++;
                end
                if (m_tdata[39:37] !== 3'b000)
                begin
                    $error("m_tdata pad bits: expected 0, got %b", m_tdata[39:37]);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // receiver: random stall before each result transfer
    initial
    begin
        int unsigned hold;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = rx_steady ? 0 : $urandom_range(0, 17);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid === 1'b1 && m_tready));
            @(negedge clk);
        end
    end

    // stimulus
    initial
    begin
        logic [4:0] dflt;
        model_prev    = 8'h00;
        model_exp     = beoa_pkg::RESET_EXPONENT;
        model_offset  = '0;
        model_default = beoa_pkg::RESET_EXPONENT;
        enc_pos       = 2'd0;
        last_sent     = 8'h00;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        n_samples     = 0;
        n_defaults    = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TABLE[i].kind == ROW_DEFAULT)
                load_default(DIR_TABLE[i].value[4:0]);
            else
                send_sample(DIR_TABLE[i].value, DIR_TABLE[i].typed,
                            {DIR_TABLE[i].offset, DIR_TABLE[i].exponent});
        end
        n_directed = n_samples;

        // random phases, each behind its own default exponent
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       dflt = 5'd31;
                1:       dflt = 5'd0;
                2:       dflt = 5'd30;
                3:       dflt = 5'($urandom_range(1, 29));
                default: dflt = beoa_pkg::RESET_EXPONENT;
            endcase
            load_default(dflt);
            tx_steady = (ph == 1) || (ph == 3);
            rx_steady = (ph == 1) || (ph == 4);
            repeat (PHASE_SAMPLES)
                send_sample(next_gpio_sample(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (offset_exp_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d gpio samples (%0d from the table), %0d results compared",
                 n_samples, n_directed, n_results);
        $display("%0d default exponent loads incl. 0, 30 and 31; %0d mismatches",
                 n_defaults, n_errors);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
design/beoa_pkg.sv
design/beoa_edge.sv
design/beoa_update.sv
design/button_encoder_offset_adjust.sv
tb/sv/button_encoder_offset_adjust_tb.sv
